// ----- hw/rtl/v3n_pkg.sv -----
// Package for the 3D vector normalizer: payload structs, widths and constants.
// Used by every module in hw/rtl; depends on nothing.
`default_nettype none
package v3n_pkg;
   localparam int unsigned COMP_W = 32;
   localparam int unsigned SUM_W = 66;
   localparam int unsigned LEN_W = 32;
   localparam int unsigned MINLEN_W = 16;
   localparam int unsigned FRAC_W = 16;
   localparam int unsigned QDEPTH_DEFAULT = 4;

   typedef struct packed {
      logic signed [COMP_W-1:0] comp_x;
      logic signed [COMP_W-1:0] comp_y;
      logic signed [COMP_W-1:0] comp_z;
   } req_type;

   typedef struct packed {
      logic signed [COMP_W-1:0] unit_x;
      logic signed [COMP_W-1:0] unit_y;
      logic signed [COMP_W-1:0] unit_z;
      logic [LEN_W-1:0] length;
      logic degenerate;
   } rsp_type;

   // Item handed from the front part (length and classification) to the back part.
   typedef struct packed {
      logic signed [COMP_W-1:0] comp_x;
      logic signed [COMP_W-1:0] comp_y;
      logic signed [COMP_W-1:0] comp_z;
      logic [LEN_W-1:0] length;
      logic degenerate;
   } job_type;

   function automatic logic [COMP_W-1:0] mag32(input logic [COMP_W-1:0] v);
      mag32 = v[COMP_W-1] ? (~v + 1'b1) : v;
   endfunction
endpackage
`default_nettype wire

// ----- hw/rtl/v3n_front.sv -----
// Front part: squares, sum, pipelined square root (one result bit per stage)
// and the compare against min_length. Depends on v3n_pkg.
`default_nettype none
module v3n_front (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic in_valid,
   input  wire v3n_pkg::req_type in_data,
   input  wire logic [v3n_pkg::MINLEN_W-1:0] min_length,
   input  wire logic advance,
   output logic out_valid,
   output v3n_pkg::job_type out_data
);
   localparam int unsigned NST = v3n_pkg::LEN_W;
   localparam int unsigned RW = v3n_pkg::SUM_W;

   logic [v3n_pkg::COMP_W-1:0] mx_ff, my_ff, mz_ff;
   v3n_pkg::req_type s0_ff;
   logic v0_ff;
   logic [63:0] sqx_ff, sqy_ff, sqz_ff;
   v3n_pkg::req_type s1_ff;
   logic v1_ff;

   logic [RW-1:0] rem_ff [NST+1];
   logic [RW-1:0] num_ff [NST+1];
   logic [NST-1:0] root_ff [NST+1];
   v3n_pkg::req_type vec_ff [NST+1];
   logic vld_ff [NST+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
      end else if (advance) begin
         v0_ff <= in_valid;
         v1_ff <= v0_ff;
      end
      if (advance) begin
         mx_ff <= v3n_pkg::mag32(in_data.comp_x);
         my_ff <= v3n_pkg::mag32(in_data.comp_y);
         mz_ff <= v3n_pkg::mag32(in_data.comp_z);
         s0_ff <= in_data;
         sqx_ff <= 64'(mx_ff) * 64'(mx_ff);
         sqy_ff <= 64'(my_ff) * 64'(my_ff);
         sqz_ff <= 64'(mz_ff) * 64'(mz_ff);
         s1_ff <= s0_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (advance) begin
         vld_ff[0] <= v1_ff;
      end
      if (advance) begin
         rem_ff[0] <= '0;
         num_ff[0] <= RW'(sqx_ff) + RW'(sqy_ff) + RW'(sqz_ff);
         root_ff[0] <= '0;
         vec_ff[0] <= s1_ff;
      end
   end

   // Restoring square root: each stage brings down two bits and decides one root bit.
   for (genvar i = 0; i < NST; i++) begin : g_root
      logic [RW-1:0] rem_sh, trial;
      always_comb begin
         rem_sh = {rem_ff[i][RW-3:0], num_ff[i][RW-1-2:RW-2-2]};
         trial = RW'({root_ff[i], 2'b01});
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i+1] <= 1'b0;
         end else if (advance) begin
            vld_ff[i+1] <= vld_ff[i];
         end
         if (advance) begin
            num_ff[i+1] <= {num_ff[i][RW-3:0], 2'b00};
            vec_ff[i+1] <= vec_ff[i];
            if (rem_sh >= trial) begin
               rem_ff[i+1] <= rem_sh - trial;
               root_ff[i+1] <= {root_ff[i][NST-2:0], 1'b1};
            end else begin
               rem_ff[i+1] <= rem_sh;
               root_ff[i+1] <= {root_ff[i][NST-2:0], 1'b0};
            end
         end
      end
   end

   always_comb begin
      out_valid = vld_ff[NST];
      out_data.comp_x = vec_ff[NST].comp_x;
      out_data.comp_y = vec_ff[NST].comp_y;
      out_data.comp_z = vec_ff[NST].comp_z;
      out_data.length = root_ff[NST];
      out_data.degenerate = root_ff[NST] <= NST'(min_length);
   end
endmodule
`default_nettype wire

// ----- hw/rtl/v3n_queue.sv -----
// Short FIFO between front and back parts. Depends on v3n_pkg.
`default_nettype none
module v3n_queue #(
   parameter int unsigned DEPTH = v3n_pkg::QDEPTH_DEFAULT
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic wr_en,
   input  wire v3n_pkg::job_type wr_data,
   input  wire logic rd_en,
   output logic rd_valid,
   output v3n_pkg::job_type rd_data,
   output logic [$clog2(DEPTH+1)-1:0] count
);
   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   v3n_pkg::job_type mem_ff [DEPTH];
   logic [AW-1:0] wp_ff, rp_ff;
   logic [$clog2(DEPTH+1)-1:0] cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (wr_en) wp_ff <= (wp_ff == AW'(DEPTH-1)) ? '0 : wp_ff + 1'b1;
         if (rd_en) rp_ff <= (rp_ff == AW'(DEPTH-1)) ? '0 : rp_ff + 1'b1;
         cnt_ff <= cnt_ff + (wr_en ? 1'b1 : 1'b0) - (rd_en ? 1'b1 : 1'b0);
      end
      if (wr_en) mem_ff[wp_ff] <= wr_data;
   end

   assign rd_valid = cnt_ff != '0;
   assign rd_data = mem_ff[rp_ff];
   assign count = cnt_ff;
endmodule
`default_nettype wire

// ----- hw/rtl/v3n_back.sv -----
// Back part: three pipelined restoring dividers (component*65536 / length),
// sign fix, pass-through for degenerate vectors, output register. Depends on v3n_pkg.
`default_nettype none
module v3n_back (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic in_valid,
   input  wire v3n_pkg::job_type in_data,
   output logic in_take,
   output logic out_valid,
   output v3n_pkg::rsp_type out_data,
   input  wire logic out_stall
);
   localparam int unsigned DW = v3n_pkg::COMP_W + v3n_pkg::FRAC_W; // dividend 48 bits
   localparam int unsigned NS = DW;
   localparam int unsigned RMW = v3n_pkg::LEN_W + 1;

   logic adv;
   logic vld_ff [NS+1];
   v3n_pkg::job_type job_ff [NS+1];
   logic [DW-1:0] quo_ff [3][NS+1];
   logic [RMW-1:0] rem_ff [3][NS+1];
   logic out_valid_ff;
   v3n_pkg::rsp_type out_ff;

   assign adv = !out_valid_ff || !out_stall;
   assign in_take = adv && in_valid;

   always_ff @(posedge clock) begin
      if (reset) vld_ff[0] <= 1'b0;
      else if (adv) vld_ff[0] <= in_valid;
      if (adv) job_ff[0] <= in_data;
   end

   for (genvar c = 0; c < 3; c++) begin : g_comp
      logic [v3n_pkg::COMP_W-1:0] raw;
      always_comb begin
         case (c)
            0: raw = in_data.comp_x;
            1: raw = in_data.comp_y;
            default: raw = in_data.comp_z;
         endcase
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            quo_ff[c][0] <= {v3n_pkg::mag32(raw), {v3n_pkg::FRAC_W{1'b0}}};
            rem_ff[c][0] <= '0;
         end
      end
      for (genvar i = 0; i < NS; i++) begin : g_div
         logic [RMW-1:0] sh;
         logic [RMW-1:0] dv;
         always_comb begin
            sh = {rem_ff[c][i][RMW-2:0], quo_ff[c][i][DW-1]};
            dv = {1'b0, job_ff[i].length};
         end
         always_ff @(posedge clock) begin
            if (adv) begin
               if (sh >= dv) begin
                  rem_ff[c][i+1] <= sh - dv;
                  quo_ff[c][i+1] <= {quo_ff[c][i][DW-2:0], 1'b1};
               end else begin
                  rem_ff[c][i+1] <= sh;
                  quo_ff[c][i+1] <= {quo_ff[c][i][DW-2:0], 1'b0};
               end
            end
         end
      end
   end

   for (genvar i = 0; i < NS; i++) begin : g_ctl
      always_ff @(posedge clock) begin
         if (reset) vld_ff[i+1] <= 1'b0;
         else if (adv) vld_ff[i+1] <= vld_ff[i];
         if (adv) job_ff[i+1] <= job_ff[i];
      end
   end

   function automatic logic [v3n_pkg::COMP_W-1:0] fix_sign(
      input logic [v3n_pkg::COMP_W-1:0] raw, input logic [DW-1:0] q);
      logic [v3n_pkg::COMP_W-1:0] qt;
      qt = q[v3n_pkg::COMP_W-1:0];
      fix_sign = raw[v3n_pkg::COMP_W-1] ? (~qt + 1'b1) : qt;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) out_valid_ff <= 1'b0;
      else if (adv) out_valid_ff <= vld_ff[NS];
      if (adv) begin
         out_ff.length <= job_ff[NS].length;
         out_ff.degenerate <= job_ff[NS].degenerate;
         if (job_ff[NS].degenerate) begin
            out_ff.unit_x <= job_ff[NS].comp_x;
            out_ff.unit_y <= job_ff[NS].comp_y;
            out_ff.unit_z <= job_ff[NS].comp_z;
         end else begin
            out_ff.unit_x <= fix_sign(job_ff[NS].comp_x, quo_ff[0][NS]);
            out_ff.unit_y <= fix_sign(job_ff[NS].comp_y, quo_ff[1][NS]);
            out_ff.unit_z <= fix_sign(job_ff[NS].comp_z, quo_ff[2][NS]);
         end
      end
   end

   assign out_valid = out_valid_ff;
   assign out_data = out_ff;
endmodule
`default_nettype wire

// ----- hw/rtl/vector3_normalize.sv -----
// 3D vector normalizer top level. An input transfer passes through the front part
// (abs, squares, sum, 32 root stages; the compare is combinational on the last
// stage), the queue and the back part (load stage, 48 divider stages, output
// register). Throughput: one transfer per cycle while neither the response side
// nor the queue stalls. Synchronous active-high reset clears all valid flags,
// the queue pointers and min_length (to 0). Depends on v3n_pkg.
`default_nettype none
module vector3_normalize #(
   parameter int unsigned QUEUE_DEPTH = v3n_pkg::QDEPTH_DEFAULT
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic req_stall,
   input  wire v3n_pkg::req_type req_data,
   output logic rsp_valid,
   input  wire logic rsp_stall,
   output v3n_pkg::rsp_type rsp_data,
   input  wire logic csr_valid,
   output logic csr_ready,
   input  wire logic [v3n_pkg::MINLEN_W-1:0] csr_data
);
   // The front pipeline moves as one unit under a single enable. It stops only
   // when its last stage holds an item, the queue is full and the back part is
   // not taking an entry in the same cycle; a read and a write may share a cycle.
   localparam int unsigned QD = QUEUE_DEPTH;

   logic [v3n_pkg::MINLEN_W-1:0] min_length_ff;
   logic front_adv;
   logic f_valid;
   v3n_pkg::job_type f_data;
   logic q_valid, q_take;
   v3n_pkg::job_type q_data;
   logic [$clog2(QD+1)-1:0] q_count;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) min_length_ff <= '0;
      else if (csr_valid) min_length_ff <= csr_data;
   end

   // Advance the front whenever its output has somewhere to go.
   assign front_adv = !f_valid || (32'(q_count) < QD) || q_take;
   assign req_stall = !front_adv;

   v3n_front u_front (
      .clock(clock), .reset(reset),
      .in_valid(req_valid), .in_data(req_data),
      .min_length(min_length_ff), .advance(front_adv),
      .out_valid(f_valid), .out_data(f_data)
   );

   v3n_queue #(.DEPTH(QD)) u_queue (
      .clock(clock), .reset(reset),
      .wr_en(f_valid && front_adv), .wr_data(f_data),
      .rd_en(q_take), .rd_valid(q_valid), .rd_data(q_data), .count(q_count)
   );

   v3n_back u_back (
      .clock(clock), .reset(reset),
      .in_valid(q_valid), .in_data(q_data), .in_take(q_take),
      .out_valid(rsp_valid), .out_data(rsp_data), .out_stall(rsp_stall)
   );
endmodule
`default_nettype wire

// ----- bench/vector3_normalize_checker.sv -----
// Checker for the 3D vector normalizer: watches the request, response and CSR
// transfers, predicts each response and compares it. Depends on v3n_pkg.
`timescale 1ns / 100ps
`default_nettype none
module vector3_normalize_checker (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   input  wire logic req_stall,
   input  wire v3n_pkg::req_type req_data,
   input  wire logic rsp_valid,
   input  wire logic rsp_stall,
   input  wire v3n_pkg::rsp_type rsp_data,
   input  wire logic csr_valid,
   input  wire logic csr_ready,
   input  wire logic [v3n_pkg::MINLEN_W-1:0] csr_data,
   output int unsigned error_count,
   output int unsigned pending_count
);
   logic [v3n_pkg::MINLEN_W-1:0] threshold;
   v3n_pkg::rsp_type expected_q[$];

   function automatic logic [63:0] floor_root(input logic [63:0] n);
      logic [63:0] res;
      logic [63:0] bit_w;
      res = 0;
      bit_w = 64'd1 << 62;
      while (bit_w > n) bit_w = bit_w >> 2;
      while (bit_w != 0) begin
         if (n >= res + bit_w) begin
            n = n - (res + bit_w);
            res = (res >> 1) + bit_w;
         end else begin
            res = res >> 1;
         end
         bit_w = bit_w >> 2;
      end
      return res;
   endfunction

   function automatic logic [63:0] abs_val(input logic [31:0] v);
      return v[31] ? (64'h1_0000_0000 - {32'd0, v}) : {32'd0, v};
   endfunction

   function automatic logic [31:0] scaled(input logic [31:0] v, input logic [63:0] len);
      logic [63:0] q;
      q = (abs_val(v) << 16) / len;
      if (v[31]) q = -q;
      return q[31:0];
   endfunction

   function automatic v3n_pkg::rsp_type normalize(input v3n_pkg::req_type r,
                                                  input logic [v3n_pkg::MINLEN_W-1:0] lim);
      v3n_pkg::rsp_type o;
      logic [63:0] sum;
      logic [63:0] len;
      sum = abs_val(r.comp_x) * abs_val(r.comp_x) + abs_val(r.comp_y) * abs_val(r.comp_y)
            + abs_val(r.comp_z) * abs_val(r.comp_z);
      len = floor_root(sum);
      o.length = len[31:0];
      if (len > {48'd0, lim}) begin
         o.unit_x = scaled(r.comp_x, len);
         o.unit_y = scaled(r.comp_y, len);
         o.unit_z = scaled(r.comp_z, len);
         o.degenerate = 1'b0;
      end else begin
         o.unit_x = r.comp_x;
         o.unit_y = r.comp_y;
         o.unit_z = r.comp_z;
         o.degenerate = 1'b1;
      end
      return o;
   endfunction

   always @(posedge clock) begin
      v3n_pkg::rsp_type want;
      if (reset) begin
         threshold <= '0;
         expected_q.delete();
         error_count <= 0;
         pending_count <= 0;
      end else begin
         if (csr_valid && csr_ready) threshold <= csr_data;
         if (req_valid && !req_stall) expected_q.push_back(normalize(req_data, threshold));
         if (rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0) begin
               $display("%0t: response with none expected: actual %h", $time, rsp_data);
               error_count <= error_count + 1;
            end else begin
               want = expected_q.pop_front();
               if (want !== rsp_data) begin
                  $display("%0t: mismatch expected x=%h y=%h z=%h len=%h deg=%b", $time,
                     want.unit_x, want.unit_y, want.unit_z, want.length, want.degenerate);
                  $display("%0t:          actual   x=%h y=%h z=%h len=%h deg=%b", $time,
                     rsp_data.unit_x, rsp_data.unit_y, rsp_data.unit_z, rsp_data.length,
                     rsp_data.degenerate);
                  error_count <= error_count + 1;
               end
            end
         end
         pending_count <= expected_q.size();
      end
   end
endmodule
`default_nettype wire

// ----- bench/vector3_normalize_test.sv -----
// Top of the normalizer testbench: clock, reset, stimulus and verdict.
// Depends on v3n_pkg, vector3_normalize and vector3_normalize_checker.
`timescale 1ns / 100ps
`default_nettype none
module vector3_normalize_test;
   localparam int unsigned PIPE_CYCLES = 100;
   localparam int unsigned IDLE_LIMIT = 5000;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   v3n_pkg::req_type req_data;
   logic rsp_valid;
   logic rsp_stall;
   v3n_pkg::rsp_type rsp_data;
   logic csr_valid;
   logic csr_ready;
   logic [v3n_pkg::MINLEN_W-1:0] csr_data;
   int unsigned error_count;
   int unsigned pending_count;

   // Receiver behavior: a long hold-off request, and a flag that turns idling off.
   bit hold_rsp;
   bit quiet;
   int unsigned idle_cycles;

   vector3_normalize u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   vector3_normalize_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data),
      .error_count(error_count), .pending_count(pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // The receiver stalls in random bursts. When hold_rsp is raised it holds off
   // for a long count of its own so the pipeline and queue fill and the
   // request side must stall too.
   initial begin
      int unsigned n;
      rsp_stall = 1'b1;
      @(posedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_stall <= 1'b1;
            repeat (400) @(posedge clock);
            hold_rsp = 1'b0;
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            n = $urandom_range(1, 19);
            repeat (n) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            n = $urandom_range(1, 30);
            repeat (n) @(posedge clock);
         end
      end
   end

   // Watchdog: cycles with no transfer on any channel.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL vector3_normalize");
            $finish;
         end
      end
   end

   // One vector transfer; an idle gap may come first.
   task automatic send_vector(input logic [31:0] x, input logic [31:0] y,
                              input logic [31:0] z);
      int unsigned gap;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         gap = $urandom_range(1, 19);
         repeat (gap) @(posedge clock);
      end
      req_data <= '{comp_x: x, comp_y: y, comp_z: z};
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (PIPE_CYCLES) @(posedge clock);
   endtask

   // Threshold changes happen only with the block drained.
   task automatic write_threshold(input logic [v3n_pkg::MINLEN_W-1:0] value);
      drain();
      csr_data <= value;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   // A random component: full range half the time, else small, extreme or zero.
   function automatic logic [31:0] pick_comp();
      case ($urandom_range(0, 7))
         0: return 32'(int'($urandom_range(0, 400)) - 200);
         1: return 32'(int'($urandom_range(0, 262144)) - 131072);
         2: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
         3: return 32'd0;
         default: return $urandom;
      endcase
   endfunction

   // Random vectors, about one in five near the threshold so both sides of the comparison occur.
   task automatic random_phase(input int unsigned count,
                               input logic [v3n_pkg::MINLEN_W-1:0] lim);
      int unsigned k;
      for (k = 0; k < count; k++) begin
         if ($urandom_range(0, 4) == 0)
            send_vector(32'(int'(lim) + int'($urandom_range(0, 4)) - 2),
                        32'($urandom_range(0, 1)), 32'd0);
         else
            send_vector(pick_comp(), pick_comp(), pick_comp());
      end
   endtask

   initial begin
      logic [v3n_pkg::MINLEN_W-1:0] mid_lim;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_data = '0;
      hold_rsp = 1'b0;
      quiet = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed vectors with the reset threshold of zero: the zero vector,
      // the smallest lengths, the largest magnitudes and sign mixes.
      send_vector(32'd0, 32'd0, 32'd0);
      send_vector(32'd1, 32'd0, 32'd0);
      send_vector(32'hFFFF_FFFF, 32'd0, 32'd0);
      send_vector(32'd0, 32'd1, 32'd1);
      send_vector(32'h0001_0000, 32'd0, 32'd0);
      send_vector(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_vector(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_vector(32'h8000_0000, 32'h7FFF_FFFF, 32'd0);
      send_vector(32'hFFFF_0000, 32'h0001_0000, 32'hFFFF_0000);
      send_vector(32'h0003_0000, 32'h0004_0000, 32'd0);
      send_vector(32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFF);
      send_vector(32'd0, 32'd0, 32'h8000_0000);

      // Maximum threshold: lengths around 65535 sit on either side of it.
      write_threshold(16'hFFFF);
      send_vector(32'd65535, 32'd0, 32'd0);
      send_vector(32'd65536, 32'd0, 32'd0);
      send_vector(32'hFFFF_0001, 32'd0, 32'd0);
      send_vector(32'hFFFF_0000, 32'd0, 32'd0);
      send_vector(32'd0, 32'd0, 32'd0);
      random_phase(250, 16'hFFFF);

      // The receiver holds off while requests keep coming.
      hold_rsp = 1'b1;
      random_phase(150, 16'hFFFF);

      write_threshold(16'd0);
      random_phase(250, 16'd0);

      // The sender pauses until every expected response has come.
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);

      mid_lim = 16'(int'($urandom_range(1, 1000)));
      write_threshold(mid_lim);
      random_phase(250, mid_lim);
      write_threshold(16'h8000);
      random_phase(200, 16'h8000);

      // Final stretch with no idling on either side.
      quiet = 1'b1;
      write_threshold(16'd1);
      random_phase(150, 16'd1);

      drain();
      if (error_count == 0) begin
         $display("PASS vector3_normalize");
      end else begin
         $display("FAIL vector3_normalize");
      end
      $finish;
   end
endmodule
`default_nettype wire
